/* src/allm_pkg.sv */
`default_nettype none

package allm_pkg;

  localparam int SLOTS  = 8;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LINK_W = IDX_W + 1;
  localparam int STEP_W = $clog2(SLOTS + 1);
  localparam int KEY_W  = 32;
  localparam int SLOT_W = 3;

  localparam logic [LINK_W-1:0] LINK_NULL = {LINK_W{1'b1}};

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NOT_FND  = 2'd2;

  typedef struct packed {
    logic              cmd;
    logic signed [KEY_W-1:0] key_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot_index;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_A,
    S_INS_B,
    S_WALK_RD,
    S_WALK_CMP,
    S_DEL_A,
    S_DEL_B,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic ins_a;
    logic ins_b;
    logic walk_rd;
    logic walk_adv;
    logic del_a;
    logic del_b;
    logic res_ok;
    logic res_full;
    logic res_miss;
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic item_cmd;
    logic free_ok;
    logic cur_ok;
    logic key_hit;
    logic out_free;
  } stat_t;

  function automatic logic is_slot(input logic [LINK_W-1:0] l);
    return l < LINK_W'(SLOTS);
  endfunction

endpackage

`default_nettype wire

/* src/array_linked_list_manager_unit.sv */
// channel | signals                       | transaction
// --------+-------------------------------+------------------------------------------
// request | req_valid, req_ready, req     | cmd insert/delete plus key_value
// result  | rsp_valid, rsp_ready, rsp     | status plus slot_index, one per request
//
// one request is worked at a time; req_ready is high only while the controller idles
// insert: two link-update states (INS_A, INS_B), then the result hand-off in DONE; with no
//   slot free it goes straight to DONE; the next request is taken back in idle
// delete: a key memory read and a compare state per list entry visited, then two unlink
//   states on a hit; one read port per link array and the registered key read
// a result waiting on rsp_ready stalls only the next hand-off; rst rebuilds free chain
`default_nettype none

module array_linked_list_manager_unit (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  allm_pkg::req_t   req,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output allm_pkg::rsp_t   rsp
);

  allm_pkg::ctrl_t ctrl;
  allm_pkg::stat_t stat;

  // sequencer for insert, walk and unlink
  allm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  // slot arrays, heads, walk pointer and result registers
  allm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ctrl      (ctrl),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // one transaction in flight: no second acceptance right after one
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("request accepted while busy");

  // a result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |-> (!rsp_valid || rsp_ready))
    else $error("result register overwritten");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    ctrl.out_load |=> rsp_valid)
    else $error("loaded result not presented");

  // at most one outcome per cycle
  a_one_outcome: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctrl.res_ok, ctrl.res_full, ctrl.res_miss}))
    else $error("conflicting outcomes");

endmodule

`default_nettype wire

/* src/allm_ctrl.sv */
`default_nettype none

module allm_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  input  allm_pkg::stat_t  stat,
  output allm_pkg::ctrl_t  ctrl
);

  allm_pkg::state_t state;
  allm_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= allm_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      allm_pkg::S_IDLE: begin
        if (req_valid) begin
          if (stat.item_cmd == allm_pkg::CMD_INSERT) begin
            state_next = stat.free_ok ? allm_pkg::S_INS_A : allm_pkg::S_DONE;
          end else begin
            state_next = allm_pkg::S_WALK_RD;
          end
        end
      end
      allm_pkg::S_INS_A:    state_next = allm_pkg::S_INS_B;
      allm_pkg::S_INS_B:    state_next = allm_pkg::S_DONE;
      allm_pkg::S_WALK_RD: begin
        state_next = stat.cur_ok ? allm_pkg::S_WALK_CMP : allm_pkg::S_DONE;
      end
      allm_pkg::S_WALK_CMP: begin
        state_next = stat.key_hit ? allm_pkg::S_DEL_A : allm_pkg::S_WALK_RD;
      end
      allm_pkg::S_DEL_A:    state_next = allm_pkg::S_DEL_B;
      allm_pkg::S_DEL_B:    state_next = allm_pkg::S_DONE;
      allm_pkg::S_DONE: begin
        if (stat.out_free) begin
          state_next = allm_pkg::S_IDLE;
        end
      end
      default:              state_next = allm_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ctrl      = '0;
    req_ready = 1'b0;
    unique case (state)
      allm_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          ctrl.load = 1'b1;
          if (stat.item_cmd == allm_pkg::CMD_INSERT && !stat.free_ok) begin
            ctrl.res_full = 1'b1;
          end
        end
      end
      allm_pkg::S_INS_A: ctrl.ins_a = 1'b1;
      allm_pkg::S_INS_B: begin
        ctrl.ins_b  = 1'b1;
        ctrl.res_ok = 1'b1;
      end
      allm_pkg::S_WALK_RD: begin
        if (stat.cur_ok) begin
          ctrl.walk_rd = 1'b1;
        end else begin
          ctrl.res_miss = 1'b1;
        end
      end
      allm_pkg::S_WALK_CMP: begin
        if (!stat.key_hit) begin
          ctrl.walk_adv = 1'b1;
        end
      end
      allm_pkg::S_DEL_A: ctrl.del_a = 1'b1;
      allm_pkg::S_DEL_B: begin
        ctrl.del_b  = 1'b1;
        ctrl.res_ok = 1'b1;
      end
      allm_pkg::S_DONE: ctrl.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* src/allm_dp.sv */
`default_nettype none

module allm_dp (
  input  wire              clk,
  input  wire              rst,
  input  allm_pkg::req_t   req,
  input  allm_pkg::ctrl_t  ctrl,
  output allm_pkg::stat_t  stat,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output allm_pkg::rsp_t   rsp
);

  logic [allm_pkg::LINK_W-1:0] next_links [allm_pkg::SLOTS];
  logic [allm_pkg::LINK_W-1:0] prev_links [allm_pkg::SLOTS];
  logic [allm_pkg::KEY_W-1:0]  slot_keys  [allm_pkg::SLOTS];

  logic [allm_pkg::LINK_W-1:0] free_head;
  logic [allm_pkg::LINK_W-1:0] list_head;
  logic [allm_pkg::LINK_W-1:0] cur;
  logic [allm_pkg::LINK_W-1:0] nxt;
  logic [allm_pkg::LINK_W-1:0] p_q;
  logic [allm_pkg::LINK_W-1:0] n_q;
  logic [allm_pkg::STEP_W-1:0] steps;
  logic [allm_pkg::KEY_W-1:0]  key_q;
  logic [allm_pkg::KEY_W-1:0]  key_rd;
  logic                        cmd_q;
  allm_pkg::rsp_t              res_q;

  logic [allm_pkg::IDX_W-1:0]  fh_idx;
  logic [allm_pkg::IDX_W-1:0]  lh_idx;
  logic [allm_pkg::IDX_W-1:0]  cur_idx;
  logic [allm_pkg::IDX_W-1:0]  p_idx;
  logic [allm_pkg::IDX_W-1:0]  n_idx;
  logic [allm_pkg::IDX_W-1:0]  nrd_addr;
  logic [allm_pkg::LINK_W-1:0] next_rd;
  logic [allm_pkg::LINK_W-1:0] prev_rd;

  assign fh_idx   = free_head[allm_pkg::IDX_W-1:0];
  assign lh_idx   = list_head[allm_pkg::IDX_W-1:0];
  assign cur_idx  = cur[allm_pkg::IDX_W-1:0];
  assign p_idx    = p_q[allm_pkg::IDX_W-1:0];
  assign n_idx    = n_q[allm_pkg::IDX_W-1:0];
  assign nrd_addr = ctrl.ins_a ? fh_idx : cur_idx;
  assign next_rd  = next_links[nrd_addr];
  assign prev_rd  = prev_links[cur_idx];

  // the accepted command is shown live in idle so the fsm can branch at once
  assign stat.item_cmd = ctrl.load ? req.cmd : cmd_q;
  assign stat.free_ok  = allm_pkg::is_slot(free_head);
  assign stat.cur_ok   = allm_pkg::is_slot(cur) && (steps < allm_pkg::STEP_W'(allm_pkg::SLOTS));
  assign stat.key_hit  = (key_rd == key_q);
  assign stat.out_free = !rsp_valid || rsp_ready;

  // link arrays and heads
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < allm_pkg::SLOTS; i++) begin
        next_links[i] <= (i + 1 < allm_pkg::SLOTS) ? allm_pkg::LINK_W'(i + 1)
                                                    : allm_pkg::LINK_NULL;
        prev_links[i] <= allm_pkg::LINK_NULL;
      end
      free_head <= '0;
      list_head <= allm_pkg::LINK_NULL;
    end else begin
      if (ctrl.ins_a) begin
        free_head          <= next_rd;
        next_links[fh_idx] <= list_head;
        prev_links[fh_idx] <= allm_pkg::LINK_NULL;
      end
      if (ctrl.ins_b) begin
        if (allm_pkg::is_slot(list_head)) begin
          prev_links[lh_idx] <= cur;
        end
        list_head <= cur;
      end
      if (ctrl.del_a) begin
        next_links[cur_idx] <= free_head;
        prev_links[cur_idx] <= allm_pkg::LINK_NULL;
        free_head           <= cur;
      end
      if (ctrl.del_b) begin
        if (allm_pkg::is_slot(p_q)) begin
          next_links[p_idx] <= n_q;
        end else begin
          list_head <= n_q;
        end
        if (allm_pkg::is_slot(n_q)) begin
          prev_links[n_idx] <= p_q;
        end
      end
    end
  end

  // key store, registered read
  always_ff @(posedge clk) begin
    if (ctrl.ins_a) begin
      slot_keys[fh_idx] <= key_q;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.walk_rd) begin
      key_rd <= slot_keys[cur_idx];
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_q <= req.key_value;
      cmd_q <= req.cmd;
      cur   <= list_head;
      steps <= '0;
    end
    if (ctrl.ins_a) begin
      cur <= free_head;
    end
    if (ctrl.walk_rd) begin
      nxt <= next_rd;
    end
    if (ctrl.walk_adv) begin
      cur   <= nxt;
      steps <= steps + 1'b1;
    end
    if (ctrl.del_a) begin
      p_q <= prev_rd;
      n_q <= next_rd;
    end
    if (ctrl.res_ok) begin
      res_q.status     <= allm_pkg::ST_DONE;
      res_q.slot_index <= allm_pkg::SLOT_W'(cur_idx);
    end
    if (ctrl.res_full) begin
      res_q.status     <= allm_pkg::ST_NO_SPACE;
      res_q.slot_index <= '0;
    end
    if (ctrl.res_miss) begin
      res_q.status     <= allm_pkg::ST_NOT_FND;
      res_q.slot_index <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      rsp <= res_q;
    end
  end

endmodule

`default_nettype wire

/* tb/array_linked_list_manager_unit_checker.sv */
`default_nettype none

module array_linked_list_manager_unit_checker (
  input  wire             clk,
  input  wire             rst,
  input  wire             req_valid,
  input  wire             req_ready,
  input  allm_pkg::req_t  req,
  input  wire             rsp_valid,
  input  wire             rsp_ready,
  input  allm_pkg::rsp_t  rsp,
  output int              fail_count,
  output int              open_count
);
  import allm_pkg::*;

  // shadow copy of the slot arrays and both list heads
  logic [LINK_W-1:0] succ_of [SLOTS];
  logic [LINK_W-1:0] pred_of [SLOTS];
  logic [KEY_W-1:0]  key_of  [SLOTS];
  logic [LINK_W-1:0] free_top;
  logic [LINK_W-1:0] list_top;

  rsp_t awaited_outcomes [$];
  int   mismatches = 0;

  initial begin
    fail_count = 0;
    open_count = 0;
  end

  function automatic rsp_t apply_list_op(input req_t r);
    logic [LINK_W-1:0] s;
    logic [LINK_W-1:0] p;
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] cur;
    int   steps;
    bit   found;
    rsp_t res;
    res = '{status: ST_DONE, slot_index: '0};
    if (r.cmd == CMD_INSERT) begin
      if (free_top >= SLOTS) begin
        res.status = ST_NO_SPACE;
      end else begin
        s = free_top;
        free_top = succ_of[s];
        succ_of[s] = list_top;
        if (list_top < SLOTS) pred_of[list_top] = s;
        pred_of[s] = LINK_NULL;
        key_of[s] = r.key_value;
        list_top = s;
        res.slot_index = s[SLOT_W-1:0];
      end
    end else begin
      cur = list_top;
      steps = 0;
      found = 1'b0;
      while (cur < SLOTS && steps < SLOTS && !found) begin
        if (key_of[cur] == r.key_value) begin
          found = 1'b1;
        end else begin
          cur = succ_of[cur];
          steps++;
        end
      end
      if (!found) begin
        res.status = ST_NOT_FND;
      end else begin
        p = pred_of[cur];
        n = succ_of[cur];
        if (p < SLOTS) succ_of[p] = n;
        else list_top = n;
        if (n < SLOTS) pred_of[n] = p;
        succ_of[cur] = free_top;
        pred_of[cur] = LINK_NULL;
        free_top = cur;
        res.slot_index = cur[SLOT_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        succ_of[i] = (i + 1 < SLOTS) ? LINK_W'(i + 1) : LINK_NULL;
        pred_of[i] = LINK_NULL;
        key_of[i]  = '0;
      end
      free_top = '0;
      list_top = LINK_NULL;
      awaited_outcomes.delete();
    end else begin
      // result first: its request was accepted on an earlier edge
      if (rsp_valid && rsp_ready) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result with nothing outstanding: status %0d slot_index %0d",
                 rsp.status, rsp.slot_index);
          mismatches++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatches++;
          end
          if (rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, rsp.slot_index);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) awaited_outcomes.push_back(apply_list_op(req));
    end
    fail_count <= mismatches;
    open_count <= awaited_outcomes.size();
  end

endmodule

`default_nettype wire

/* tb/array_linked_list_manager_unit_test.sv */
`default_nettype none

module array_linked_list_manager_unit_test;
  import allm_pkg::*;

  localparam int RANDOM_ITEMS    = 1580;
  // cycles with no transaction on either channel before the run is called hung
  localparam int NO_ACCEPT_LIMIT = 4000;
  // margin after the last result, sized from the worst-case delete walk
  localparam int DRAIN_CYCLES    = 2 * SLOTS + 8;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic rsp_ready = 1'b0;
  req_t req       = '0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int          fail_count;
  int          open_count;
  int          quiet_cycles = 0;
  int unsigned snd_idle_pct = 22;
  int unsigned rcv_idle_pct = 54;

  // small key pool so deletes find their keys and duplicates show up
  logic [KEY_W-1:0] key_pool [6];
  bit               lean_insert = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  array_linked_list_manager_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  array_linked_list_manager_unit_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready),
    .rsp        (rsp),
    .fail_count (fail_count),
    .open_count (open_count)
  );

  // receiver stalls at random, one fresh draw per cycle
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // hang detection: any accepted transaction resets the count
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= NO_ACCEPT_LIMIT) begin
      $display("array_linked_list_manager_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request transaction: optional sender gap, then hold valid until accepted
  task automatic send_item(input logic cmd, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < snd_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= {cmd, key};
    do @(posedge clk); while (!req_ready);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(9) < 7) return key_pool[$urandom_range(5)];
    return $urandom();
  endfunction

  initial begin
    logic cmd;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    key_pool[4] = $urandom();
    key_pool[5] = $urandom();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // delete on an empty list misses
    send_item(CMD_DELETE, 32'h0000_0000);
    // fill every slot, extremes of the key range first, one duplicate key
    send_item(CMD_INSERT, 32'h8000_0000);
    send_item(CMD_INSERT, 32'h7fff_ffff);
    send_item(CMD_INSERT, 32'h0000_0000);
    send_item(CMD_INSERT, 32'hffff_ffff);
    send_item(CMD_INSERT, 32'h1234_5678);
    send_item(CMD_INSERT, 32'h7fff_ffff);
    send_item(CMD_INSERT, 32'h5a5a_5a5a);
    send_item(CMD_INSERT, 32'ha5a5_a5a5);
    // no free slot left
    send_item(CMD_INSERT, 32'h0000_0001);
    // duplicate: the copy nearer the head goes first, from mid-list
    send_item(CMD_DELETE, 32'h7fff_ffff);
    // head delete, then tail delete
    send_item(CMD_DELETE, 32'ha5a5_a5a5);
    send_item(CMD_DELETE, 32'h8000_0000);
    // miss on a populated list leaves every slot alone
    send_item(CMD_DELETE, 32'h0000_0033);
    // freed slot comes back from the free list head
    send_item(CMD_INSERT, 32'h0000_0033);
    send_item(CMD_DELETE, 32'h7fff_ffff);
    // drain the list completely
    send_item(CMD_DELETE, 32'hffff_ffff);
    send_item(CMD_DELETE, 32'h0000_0000);
    send_item(CMD_DELETE, 32'h1234_5678);
    send_item(CMD_DELETE, 32'h5a5a_5a5a);
    send_item(CMD_DELETE, 32'h0000_0033);
    send_item(CMD_DELETE, 32'h0000_0033);
    // single entry: head delete with no successor
    send_item(CMD_INSERT, 32'hdead_beef);
    send_item(CMD_DELETE, 32'hdead_beef);

    // random part: alternate insert-heavy and delete-heavy stretches so the
    // list swings between full and empty
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        snd_idle_pct = 54;
        rcv_idle_pct = 22;
      end
      if (i == 2 * RANDOM_ITEMS / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      if (i % 40 == 0) begin
        lean_insert = ~lean_insert;
        key_pool[$urandom_range(5)] = $urandom();
      end
      if ($urandom_range(99) < 75) cmd = lean_insert ? CMD_INSERT : CMD_DELETE;
      else cmd = lean_insert ? CMD_DELETE : CMD_INSERT;
      send_item(cmd, pick_key());
    end
    req_valid <= 1'b0;

    // let the checker register the last request, then wait for every result
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("array_linked_list_manager_unit_test: clean");
    end else begin
      $display("array_linked_list_manager_unit_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
